### hdl/pse_pkg.sv
// Package with shared codes, constants and the command type of the cipher unit.
`timescale 1ns / 1ps
package pse_pkg;

    // Fixed alphabet and character codes
    localparam int unsigned ALPHABET_SIZE = 26;
    localparam logic [7:0]  LETTER_A      = 8'h61;
    localparam logic [7:0]  LETTER_Z      = 8'h7a;
    localparam logic [7:0]  CHAR_NEWLINE  = 8'h0a;
    localparam logic [7:0]  PRINT_LO      = 8'h20;
    localparam logic [7:0]  PRINT_HI      = 8'h7e;

    // Register index of the rows-in-use register (paddr bit 2)
    localparam logic        REG_ROWS_IN_USE = 1'b0;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EOM      = 2'd1,
        ST_BAD_TEXT = 2'd2,
        ST_BAD_KEY  = 2'd3
    } t_status;

    // Work kinds for the back end
    typedef enum logic [1:0] {
        CMD_PASS   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_WRITE  = 2'd2
    } t_cmd_kind;

    // Classified item handed from front to back
    typedef struct packed {
        t_cmd_kind  kind;
        t_status    status;
        logic [7:0] pass_byte;
        logic [4:0] letter;
    } t_cmd;

endpackage

### hdl/pse_front.sv
// Front end: accepts items, classifies them and tracks the key row position.
`timescale 1ns / 1ps
module pse_front
    import pse_pkg::*;
#(
    parameter int unsigned MAX_ROWS = 32,
    parameter int unsigned ADDR_W   = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [7:0]        i_text_byte,
    input  logic [4:0]        i_key_row,
    input  logic [4:0]        i_key_column,
    input  logic [7:0]        i_key_letter,
    input  logic [5:0]        i_rows_in_use,
    input  logic              i_queue_full,
    output logic              o_push,
    output t_cmd              o_cmd,
    output logic [ADDR_W-1:0] o_addr
);

    localparam int unsigned POS_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CMP_RAW = $clog2(MAX_ROWS + 1);
    localparam int unsigned CMP_W  = ((CMP_RAW > 6) ? CMP_RAW : 6) + 1;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [CMP_W-1:0] eff_rows;
    logic [CMP_W-1:0] row_sel;
    logic [CMP_W-1:0] row_inc;
    logic             accept;
    logic             key_ok;
    logic             is_lower;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign o_push     = accept;

    // Clamp the configured row count to 1..MAX_ROWS
    always_comb begin
        if (i_rows_in_use == 6'd0) begin
            eff_rows = CMP_W'(1);
        end else if (CMP_W'(i_rows_in_use) > CMP_W'(MAX_ROWS)) begin
            eff_rows = CMP_W'(MAX_ROWS);
        end else begin
            eff_rows = CMP_W'(i_rows_in_use);
        end
    end

    // Pick the current row and the wrapped next one
    assign row_sel  = (CMP_W'(r_pos) < eff_rows) ? CMP_W'(r_pos) : '0;
    assign row_inc  = row_sel + CMP_W'(1);
    assign is_lower = (i_text_byte >= LETTER_A) && (i_text_byte <= LETTER_Z);
    assign key_ok   = (i_key_letter >= LETTER_A) && (i_key_letter <= LETTER_Z) &&
                      (CMP_W'(i_key_column) < CMP_W'(ALPHABET_SIZE)) &&
                      (CMP_W'(i_key_row) < CMP_W'(MAX_ROWS));

    // Classify the item
    always_comb begin
        o_cmd.kind      = CMD_PASS;
        o_cmd.status    = ST_OK;
        o_cmd.pass_byte = 8'h00;
        o_cmd.letter    = 5'(i_key_letter - LETTER_A);
        o_addr          = '0;
        n_pos           = r_pos;
        if (i_req_type) begin
            o_addr = ADDR_W'(ADDR_W'(i_key_row) * ADDR_W'(ALPHABET_SIZE)
                     + ADDR_W'(i_key_column));
            if (key_ok) begin
                o_cmd.kind = CMD_WRITE;
            end else begin
                o_cmd.status = ST_BAD_KEY;
            end
        end else if (i_text_byte == CHAR_NEWLINE) begin
            o_cmd.status    = ST_EOM;
            o_cmd.pass_byte = CHAR_NEWLINE;
            n_pos           = '0;
        end else if ((i_text_byte < PRINT_LO) || (i_text_byte > PRINT_HI)) begin
            o_cmd.status = ST_BAD_TEXT;
            n_pos        = '0;
        end else begin
            o_addr = ADDR_W'(ADDR_W'(row_sel) * ADDR_W'(ALPHABET_SIZE)
                     + ADDR_W'(i_text_byte - LETTER_A));
            if (is_lower) begin
                o_cmd.kind = CMD_LOOKUP;
            end else begin
                o_cmd.pass_byte = i_text_byte;
            end
            n_pos = (row_inc >= eff_rows) ? '0 : POS_W'(row_inc);
        end
    end

    // Update the position (advance, restart or hold) on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    // A printable character leaves the position inside the row range
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_req_type && (i_text_byte >= PRINT_LO) && (i_text_byte <= PRINT_HI))
        |=> (CMP_W'(r_pos) < $past(eff_rows)))
        else $error("position left the configured row range");

    // Message end and bad bytes restart the position
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_req_type &&
         ((i_text_byte < PRINT_LO) || (i_text_byte > PRINT_HI)))
        |=> (r_pos == '0))
        else $error("position not restarted at message end");

endmodule

### hdl/pse_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module pse_queue #(
    parameter int unsigned W = 27
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Move the pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from an empty queue");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue count did not drop on pop");

endmodule

### hdl/pse_back.sv
// Back end: key table memory, lookups and the result register.
`timescale 1ns / 1ps
module pse_back
    import pse_pkg::*;
#(
    parameter int unsigned MAX_ROWS = 32,
    parameter int unsigned ADDR_W   = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  t_cmd              i_head_cmd,
    input  logic [ADDR_W-1:0] i_head_addr,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_cipher_byte,
    output logic [1:0]        o_status
);

    localparam int unsigned DEPTH = MAX_ROWS * ALPHABET_SIZE;

    logic [4:0] r_table [DEPTH];
    logic [4:0] r_rd_data;
    t_cmd       r_s1_cmd;
    logic       r_s1_valid;
    logic       n_s1_valid;
    logic       advance;

    // Take the next command only when the result slot frees up
    assign advance = !r_s1_valid || i_out_ready;
    assign o_pop   = i_head_valid && advance;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_pop) begin
            n_s1_valid = 1'b1;
        end else if (i_out_ready) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // Load the result stage
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd <= i_head_cmd;
        end
    end

    // Key table: write or registered read at the popped address
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head_cmd.kind == CMD_WRITE)) begin
            r_table[i_head_addr] <= i_head_cmd.letter;
        end
        if (o_pop && (i_head_cmd.kind == CMD_LOOKUP)) begin
            r_rd_data <= r_table[i_head_addr];
        end
    end

    // Drive the result
    assign o_out_valid   = r_s1_valid;
    assign o_cipher_byte = (r_s1_cmd.kind == CMD_LOOKUP) ? (LETTER_A + {3'b000, r_rd_data})
                                                          : r_s1_cmd.pass_byte;
    assign o_status      = r_s1_cmd.status;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_out_ready)
        |=> (r_s1_valid && $stable(o_cipher_byte) && $stable(r_s1_cmd)))
        else $error("result changed while stalled");

    a_write_result_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_cmd.kind == CMD_WRITE))
        |-> ((o_cipher_byte == 8'h00) && (o_status == ST_OK)))
        else $error("key write gave a nonzero result");

endmodule

### hdl/polyalphabetic_substitution_encrypt_unit.sv
// Top level of the polyalphabetic substitution cipher unit.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready  | req_type, text_byte, key_row/col/letter
//  out     | output    | o_out_valid / i_out_ready| cipher_byte, status
//  cfg     | input     | psel/penable/pwrite      | rows_in_use at byte address 0
//
//  One item per cycle sustained while the output is ready; a result passes the queue
//  slot, then the result register (and the key table read register for a lookup).
//  The four-entry queue and the result register hold five items, so the input keeps
//  taking items while the output stalls; o_in_ready drops once the queue is full.
//  Reset clears position, queue and result valid; the key table has no reset
//  and holds garbage until each entry is written.
`timescale 1ns / 1ps
module polyalphabetic_substitution_encrypt_unit
    import pse_pkg::*;
#(
    parameter int unsigned MAX_ROWS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_text_byte,
    input  logic [4:0]  i_key_row,
    input  logic [4:0]  i_key_column,
    input  logic [7:0]  i_key_letter,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_cipher_byte,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned ADDR_W = $clog2(MAX_ROWS * ALPHABET_SIZE);
    localparam int unsigned QW     = $bits(t_cmd) + ADDR_W;

    logic [5:0]        r_rows_in_use;
    logic              cfg_write;
    logic              push;
    logic              queue_full;
    t_cmd              front_cmd;
    logic [ADDR_W-1:0] front_addr;
    logic              head_valid;
    logic [QW-1:0]     head_data;
    t_cmd              head_cmd;
    logic [ADDR_W-1:0] head_addr;
    logic              pop;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ROWS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= 6'd1;
        end else if (cfg_write) begin
            r_rows_in_use <= pwdata[5:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROWS_IN_USE) ? {26'd0, r_rows_in_use} : 32'd0;

    pse_front #(
        .MAX_ROWS (MAX_ROWS),
        .ADDR_W   (ADDR_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_text_byte   (i_text_byte),
        .i_key_row     (i_key_row),
        .i_key_column  (i_key_column),
        .i_key_letter  (i_key_letter),
        .i_rows_in_use (r_rows_in_use),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .o_addr        (front_addr)
    );

    pse_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_addr, front_cmd}),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_data)
    );

    // Split the queued word back into address and command
    assign head_cmd  = t_cmd'(head_data[$bits(t_cmd)-1:0]);
    assign head_addr = head_data[QW-1:$bits(t_cmd)];

    pse_back #(
        .MAX_ROWS (MAX_ROWS),
        .ADDR_W   (ADDR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head_cmd    (head_cmd),
        .i_head_addr   (head_addr),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cipher_byte (o_cipher_byte),
        .o_status      (o_status)
    );

endmodule
